// ===== src/aavr_pkg.sv =====
// Shared constants and types for the axis-angle vector rotation pipeline.
package aavr_pkg;

    localparam int ANGLE_W      = 16;   // angle word, Q3.13 radians
    localparam int ANGLE_SHIFT  = 17;   // Q3.13 -> Q.30
    localparam int AQ_W         = 34;   // widened angle before range folding
    localparam int CS_W         = 33;   // CORDIC datapath width
    localparam int CORDIC_ITERS = 30;
    localparam int UNIT_W       = 17;   // signed Q1.15 unit axis, cosine and sine
    localparam int UNIT_FRAC    = 15;
    localparam int QUOT_W       = 16;   // quotient bits of the axis normalizer

    typedef logic signed [CS_W-1:0]   cordic_word_t;
    typedef logic signed [AQ_W-1:0]   angle_q30_t;
    typedef logic signed [UNIT_W-1:0] unit_t;

    localparam cordic_word_t CORDIC_INV_GAIN = 33'sd652032874;
    localparam angle_q30_t   PI_Q30          = 34'sd3373259426;
    localparam angle_q30_t   HALF_PI_Q30     = 34'sd1686629713;

    // atan(2^-i) in Q.30
    localparam cordic_word_t ATAN_Q30 [CORDIC_ITERS] = '{
        33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
        33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
        33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
        33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
        33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
        33'sd1023,      33'sd511,       33'sd255,       33'sd127,
        33'sd63,        33'sd31,        33'sd15,        33'sd8,
        33'sd4,         33'sd2
    };

endpackage

// ===== src/axis_angle_vector_rotate_unit.sv =====
// Rotates a 3D vector about an arbitrary axis by an angle (Rodrigues form), fully pipelined.
// One word is taken per clock and one result word leaves per clock while the output is not
// stalled. It is built from the COMP_WIDTH-step square-root pipeline, the 16-step divider
// that normalizes the axis and the multiply stages that build the matrix and the dot
// products; the 30-step CORDIC for cosine and sine runs beside the root and divider
// stages. The whole pipeline holds while a finished word waits at the output.
// An all-zero axis gives a zero vector with axis_zero set.
module axis_angle_vector_rotate_unit #(
    parameter int COMP_WIDTH = 16,
    localparam int S_TDATA_W = ((6 * COMP_WIDTH + aavr_pkg::ANGLE_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((3 * COMP_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_x, out_y, out_z, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // axis_zero, saturated
    output logic [1:0]           m_tuser
);
    import aavr_pkg::*;

    localparam int W       = COMP_WIDTH;
    localparam int SQ_W    = 2 * W;
    localparam int DIV_W   = W + UNIT_FRAC;
    localparam int PR_W    = 2 * UNIT_W;
    localparam int M_W     = 52;
    localparam int E_W     = 32;
    localparam int P_W     = E_W + W;
    localparam int SUM_W   = P_W + 2;
    localparam int R_W     = SUM_W - 28;

    localparam int ST_CS   = CORDIC_ITERS + 2;
    localparam int ST_LEN  = W + 3;
    localparam int ST_DIV  = W + 4;
    localparam int ST_UNIT = W + 21;
    localparam int ST_PROD = W + 22;
    localparam int ST_MIX  = W + 23;
    localparam int ST_MAT  = W + 24;
    localparam int ST_DOT  = W + 25;
    localparam int ST_SUM  = W + 26;
    localparam int NST     = W + 27;

    localparam logic [CS_W-1:0]        RND15    = CS_W'(1) << 14;
    localparam logic [M_W-1:0]         RND17    = M_W'(1) << 16;
    localparam logic [SUM_W-1:0]       RND28    = SUM_W'(1) << 27;
    localparam logic signed [PR_W-1:0] ONE_Q30  = PR_W'(1) << 30;
    localparam logic [QUOT_W-1:0]      UNIT_ONE = QUOT_W'(1) << UNIT_FRAC;
    localparam logic signed [R_W-1:0]  CLIP_HI  = R_W'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [R_W-1:0]  CLIP_LO  = ~CLIP_HI;

    // pipeline control
    logic [NST:1] valid_reg;
    logic         adv;

    // input fields
    logic signed [W-1:0]       in_vec [3];
    logic signed [W-1:0]       in_axis [3];
    logic signed [ANGLE_W-1:0] in_angle;

    // delay lines
    logic signed [W-1:0] vec_d [1:ST_MAT][3];
    logic signed [W-1:0] ax_d [1:ST_UNIT-1][3];
    logic                zero_d [3:ST_SUM];
    unit_t               cos_d [ST_CS:ST_PROD];
    unit_t               sin_d [ST_CS:ST_UNIT];

    // squares, length, root
    logic signed [SQ_W-1:0] sq_next [3];
    logic [SQ_W-1:0]        sq_reg [3];
    logic [SQ_W-1:0]        len2_reg;
    logic [W+1:0]           rt_rem_reg [0:W-1];
    logic [W-1:0]           rt_root_reg [0:W-1];
    logic [SQ_W-1:0]        rt_n_reg [0:W-2];
    logic [W-1:0]           len_reg;

    // divider
    logic [W-1:0]      dv_rem_reg [0:QUOT_W-1][3];
    logic [QUOT_W-1:0] dv_low_reg [0:QUOT_W-1][3];
    logic [QUOT_W-1:0] dv_q_reg [1:QUOT_W][3];
    logic [W-1:0]      dv_len_reg [0:QUOT_W-1];

    // angle folding and CORDIC
    angle_q30_t   ang_q30;
    angle_q30_t   z_fold;
    cordic_word_t z1_next;
    logic         neg1_next;
    cordic_word_t z1_reg;
    logic         neg1_reg;
    cordic_word_t cr_x_reg [0:CORDIC_ITERS-1];
    cordic_word_t cr_y_reg [0:CORDIC_ITERS-1];
    cordic_word_t cr_z_reg [0:CORDIC_ITERS-2];
    logic         cr_neg_reg [0:CORDIC_ITERS-1];
    cordic_word_t cos_v, sin_v;
    logic [CS_W-1:0] cos_rnd, sin_rnd;

    // matrix and dot products
    unit_t                    unit_reg [3];
    logic signed [PR_W-1:0]   pr_sq_reg [3];
    logic signed [PR_W-1:0]   pr_cr_reg [3];
    logic signed [PR_W-1:0]   pr_ps_reg [3];
    logic signed [17:0]       omc;
    logic signed [PR_W-1:0]   oms [3];
    logic signed [M_W-1:0]    mx_dg_reg [3];
    logic signed [M_W-1:0]    mx_od_reg [3];
    logic signed [PR_W-1:0]   mx_sq_reg [3];
    logic signed [PR_W-1:0]   mx_ps_reg [3];
    logic signed [E_W-1:0]    mat_next [3][3];
    logic signed [E_W-1:0]    mat_reg [3][3];
    logic signed [P_W-1:0]    dot_reg [3][3];
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [W-1:0]      clip_val [3];
    logic [2:0]               clip_hit;
    logic [W-1:0]             out_reg [3];
    logic                     zero_reg;
    logic                     sat_reg;

    // advance the whole pipeline unless the output word is stuck
    assign adv      = !valid_reg[NST] || m_tready;
    assign s_tready = adv;

    // unpack the input word
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign in_vec[i]  = s_tdata[i*W +: W];
        assign in_axis[i] = s_tdata[(3+i)*W +: W];
        assign sq_next[i] = in_axis[i] * in_axis[i];
    end
    assign in_angle = s_tdata[6*W +: ANGLE_W];

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NST-1:1], s_tvalid};
        end
    end

    // fold the angle into minus pi/2 .. pi/2, negate cos and sin when folded
    assign ang_q30 = {{(AQ_W-ANGLE_W-ANGLE_SHIFT){in_angle[ANGLE_W-1]}}, in_angle,
                      {ANGLE_SHIFT{1'b0}}};
    always_comb begin
        if (ang_q30 > HALF_PI_Q30) begin
            z_fold    = ang_q30 - PI_Q30;
            neg1_next = 1'b1;
        end else if (ang_q30 < -HALF_PI_Q30) begin
            z_fold    = ang_q30 + PI_Q30;
            neg1_next = 1'b1;
        end else begin
            z_fold    = ang_q30;
            neg1_next = 1'b0;
        end
        z1_next = cordic_word_t'(z_fold);
    end

    // stage 1 and 2: register inputs, square and sum the axis; shift the side payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                vec_d[1][i] <= in_vec[i];
                ax_d[1][i]  <= in_axis[i];
                sq_reg[i]   <= sq_next[i];
            end
            z1_reg   <= z1_next;
            neg1_reg <= neg1_next;
            len2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            zero_d[3] <= (len2_reg == '0);
            dv_len_reg[0] <= len_reg;
            for (int k = 2; k <= ST_MAT; k++) vec_d[k] <= vec_d[k-1];
            for (int k = 2; k <= ST_UNIT - 1; k++) ax_d[k] <= ax_d[k-1];
            for (int k = 4; k <= ST_SUM; k++) zero_d[k] <= zero_d[k-1];
            for (int k = 1; k < QUOT_W; k++) dv_len_reg[k] <= dv_len_reg[k-1];
        end
    end

    // square root, one bit pair per stage
    for (genvar j = 0; j < W; j++) begin : g_root
        logic [W+1:0]    rem_in;
        logic [W-1:0]    root_in;
        logic [SQ_W-1:0] n_in;
        logic [W+3:0]    trial, test, diff;
        logic            ge;
        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = len2_reg;
        end else begin : g_rest
            assign rem_in  = rt_rem_reg[j-1];
            assign root_in = rt_root_reg[j-1];
            assign n_in    = rt_n_reg[j-1];
        end
        assign trial = {rem_in, n_in[SQ_W-1 -: 2]};
        assign test  = {2'b00, root_in, 2'b01};
        assign ge    = (trial >= test);
        assign diff  = trial - test;
        always_ff @(posedge aclk) begin
            if (adv) begin
                rt_rem_reg[j]  <= ge ? diff[W+1:0] : trial[W+1:0];
                rt_root_reg[j] <= {root_in[W-2:0], ge};
            end
        end
        if (j < W - 1) begin : g_shift
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rt_n_reg[j] <= {n_in[SQ_W-3:0], 2'b00};
                end
            end
        end
    end

    // round the root to nearest
    always_ff @(posedge aclk) begin
        if (adv) begin
            len_reg <= rt_root_reg[W-1]
                     + W'(rt_rem_reg[W-1] > {2'b00, rt_root_reg[W-1]});
        end
    end

    // form the rounded dividends |a| * 2^15 + len / 2
    for (genvar i = 0; i < 3; i++) begin : g_dvin
        logic [W-1:0]     mag;
        logic [DIV_W-1:0] dividend;
        assign mag      = ax_d[ST_LEN][i][W-1] ? W'(-ax_d[ST_LEN][i]) : ax_d[ST_LEN][i];
        assign dividend = {mag, {UNIT_FRAC{1'b0}}} + DIV_W'(len_reg >> 1);
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[0][i] <= {1'b0, dividend[DIV_W-1:QUOT_W]};
                dv_low_reg[0][i] <= dividend[QUOT_W-1:0];
            end
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 1; k <= QUOT_W; k++) begin : g_div
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [W:0] trial, diff;
            logic       ge;
            assign trial = {dv_rem_reg[k-1][i], dv_low_reg[k-1][i][QUOT_W-1]};
            assign ge    = (trial >= {1'b0, dv_len_reg[k-1]});
            assign diff  = trial - {1'b0, dv_len_reg[k-1]};
            if (k == 1) begin : g_q0
                always_ff @(posedge aclk) begin
                    if (adv) dv_q_reg[k][i] <= {{(QUOT_W-1){1'b0}}, ge};
                end
            end else begin : g_qn
                always_ff @(posedge aclk) begin
                    if (adv) dv_q_reg[k][i] <= {dv_q_reg[k-1][i][QUOT_W-2:0], ge};
                end
            end
            if (k < QUOT_W) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        dv_rem_reg[k][i] <= ge ? diff[W-1:0] : trial[W-1:0];
                        dv_low_reg[k][i] <= {dv_low_reg[k-1][i][QUOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // CORDIC rotation, one iteration per stage
    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
        cordic_word_t x_in, y_in, z_in, dx, dy;
        logic         neg_in;
        if (i == 0) begin : g_first
            assign x_in   = CORDIC_INV_GAIN;
            assign y_in   = '0;
            assign z_in   = z1_reg;
            assign neg_in = neg1_reg;
        end else begin : g_rest
            assign x_in   = cr_x_reg[i-1];
            assign y_in   = cr_y_reg[i-1];
            assign z_in   = cr_z_reg[i-1];
            assign neg_in = cr_neg_reg[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!z_in[CS_W-1]) begin
                    cr_x_reg[i] <= x_in - dx;
                    cr_y_reg[i] <= y_in + dy;
                end else begin
                    cr_x_reg[i] <= x_in + dx;
                    cr_y_reg[i] <= y_in - dy;
                end
                cr_neg_reg[i] <= neg_in;
            end
        end
        if (i < CORDIC_ITERS - 1) begin : g_angle
            always_ff @(posedge aclk) begin
                if (adv) begin
                    cr_z_reg[i] <= z_in[CS_W-1] ? z_in + ATAN_Q30[i] : z_in - ATAN_Q30[i];
                end
            end
        end
    end

    // unfold sign and round cos and sin to Q1.15, then delay them
    assign cos_v   = cr_neg_reg[CORDIC_ITERS-1] ? -cr_x_reg[CORDIC_ITERS-1]
                                                :  cr_x_reg[CORDIC_ITERS-1];
    assign sin_v   = cr_neg_reg[CORDIC_ITERS-1] ? -cr_y_reg[CORDIC_ITERS-1]
                                                :  cr_y_reg[CORDIC_ITERS-1];
    assign cos_rnd = cos_v + RND15 - CS_W'(cos_v[CS_W-1]);
    assign sin_rnd = sin_v + RND15 - CS_W'(sin_v[CS_W-1]);
    always_ff @(posedge aclk) begin
        if (adv) begin
            cos_d[ST_CS] <= cos_rnd[UNIT_FRAC +: UNIT_W];
            sin_d[ST_CS] <= sin_rnd[UNIT_FRAC +: UNIT_W];
            for (int k = ST_CS + 1; k <= ST_PROD; k++) cos_d[k] <= cos_d[k-1];
            for (int k = ST_CS + 1; k <= ST_UNIT; k++) sin_d[k] <= sin_d[k-1];
        end
    end

    // signed unit axis, then axis products
    assign omc = 18'sd32768 - {cos_d[ST_PROD][UNIT_W-1], cos_d[ST_PROD]};
    for (genvar i = 0; i < 3; i++) begin : g_prod
        logic [UNIT_W-1:0] qe;
        assign qe     = {1'b0, dv_q_reg[QUOT_W][i]};
        assign oms[i] = ONE_Q30 - pr_sq_reg[i];
        always_ff @(posedge aclk) begin
            if (adv) begin
                unit_reg[i]  <= ax_d[ST_UNIT-1][i][W-1] ? unit_t'(-qe) : unit_t'(qe);
                pr_sq_reg[i] <= unit_reg[i] * unit_reg[i];
                pr_cr_reg[i] <= unit_reg[(i+1)%3] * unit_reg[(i+2)%3];
                pr_ps_reg[i] <= unit_reg[i] * sin_d[ST_UNIT];
                mx_dg_reg[i] <= oms[i] * cos_d[ST_PROD];
                mx_od_reg[i] <= pr_cr_reg[i] * omc;
                mx_sq_reg[i] <= pr_sq_reg[i];
                mx_ps_reg[i] <= pr_ps_reg[i];
            end
        end
    end

    // matrix entries in Q.45, rounded to Q.28
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            logic signed [M_W-1:0] me;
            logic [M_W-1:0]        rnd;
            if (i == j) begin : g_diag
                assign me = (M_W'(mx_sq_reg[i]) <<< UNIT_FRAC) + mx_dg_reg[i];
            end else if (j == (i + 1) % 3) begin : g_minus
                assign me = mx_od_reg[3-i-j] - (M_W'(mx_ps_reg[3-i-j]) <<< UNIT_FRAC);
            end else begin : g_plus
                assign me = mx_od_reg[3-i-j] + (M_W'(mx_ps_reg[3-i-j]) <<< UNIT_FRAC);
            end
            assign rnd = me + RND17 - M_W'(me[M_W-1]);
            assign mat_next[i][j] = rnd[17 +: E_W];
            always_ff @(posedge aclk) begin
                if (adv) begin
                    mat_reg[i][j] <= mat_next[i][j];
                    dot_reg[i][j] <= mat_reg[i][j] * vec_d[ST_MAT][j];
                end
            end
        end
    end

    // sum the dot products, round by 2^-28 and clip
    for (genvar i = 0; i < 3; i++) begin : g_out
        logic [SUM_W-1:0]      rnd;
        logic signed [R_W-1:0] r;
        assign rnd = sum_reg[i] + RND28 - SUM_W'(sum_reg[i][SUM_W-1]);
        assign r   = rnd[28 +: R_W];
        always_comb begin
            if (r > CLIP_HI) begin
                clip_val[i] = CLIP_HI[W-1:0];
                clip_hit[i] = 1'b1;
            end else if (r < CLIP_LO) begin
                clip_val[i] = CLIP_LO[W-1:0];
                clip_hit[i] = 1'b1;
            end else begin
                clip_val[i] = r[W-1:0];
                clip_hit[i] = 1'b0;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sum_reg[i] <= SUM_W'(dot_reg[i][0]) + SUM_W'(dot_reg[i][1])
                            + SUM_W'(dot_reg[i][2]);
                out_reg[i] <= zero_d[ST_SUM] ? '0 : clip_val[i];
            end
        end
    end

    // output flags
    always_ff @(posedge aclk) begin
        if (adv) begin
            zero_reg <= zero_d[ST_SUM];
            sat_reg  <= !zero_d[ST_SUM] && (|clip_hit);
        end
    end

    // drive the result word
    assign m_tvalid = valid_reg[NST];
    assign m_tuser  = {sat_reg, zero_reg};
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < 3; i++) m_tdata[i*W +: W] = out_reg[i];
    end

    // final root remainder never exceeds twice the root
    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_LEN-1] |-> rt_rem_reg[W-1] <= {1'b0, rt_root_reg[W-1], 1'b0})
        else $error("square root remainder out of range");

    // normalized axis components never exceed one
    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_UNIT-1] && !zero_d[ST_UNIT-1] |->
            (dv_q_reg[QUOT_W][0] <= UNIT_ONE) && (dv_q_reg[QUOT_W][1] <= UNIT_ONE) &&
            (dv_q_reg[QUOT_W][2] <= UNIT_ONE))
        else $error("unit axis component above one");

    // a stalled output freezes every stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NST] && !m_tready |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    // zero axis gives a clean zero word
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            !m_tuser[1] && (out_reg[0] == '0) && (out_reg[1] == '0) && (out_reg[2] == '0))
        else $error("zero axis word not cleared");

endmodule

// ===== tb/axis_angle_vector_rotate_unit_test.sv =====
// Self-checking testbench for the axis-angle vector rotation unit.
`timescale 1ns / 100ps

module axis_angle_vector_rotate_unit_test;

    localparam int COMP_W     = 16;
    localparam int S_W        = 112;
    localparam int M_W        = 48;
    localparam int RAND_ITEMS = 1850;
    localparam int LATENCY    = COMP_W + 27;
    localparam int CYCLE_CAP  = 200000;

    typedef struct {
        logic signed [15:0] vx, vy, vz;
        logic signed [15:0] ax, ay, az;
        logic signed [15:0] ang;
    } rot_word_t;

    typedef struct {
        logic signed [15:0] ox, oy, oz;
        logic               zero_axis;
        logic               clipped;
    } rot_result_t;

    typedef struct {
        rot_word_t   w;
        bit          typed;
        rot_result_t res;
    } stim_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic [1:0]     m_tuser;

    rot_result_t expected_rotations[$];
    stim_row_t   stim_table[$];
    int          mismatches = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          clipped_seen = 0;
    int          zero_seen = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    axis_angle_vector_rotate_unit #(.COMP_WIDTH(COMP_W)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        // out_x, out_y, out_z
        .m_tdata (m_tdata),
        // axis_zero, saturated
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // round to nearest, ties away from zero
    function automatic longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // nearest integer square root
    function automatic longint root_nearest(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= n)
                r = r | (longint'(1) << b);
        end
        if (n - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic longint unit_part(longint a, longint len);
        longint q;
        q = (((a < 0) ? -a : a) * 32768 + len / 2) / len;
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v, inout logic hit);
        if (v > 32767) begin
            hit = 1'b1;
            return 16'sd32767;
        end
        if (v < -32768) begin
            hit = 1'b1;
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    // expected rotation of one word
    function automatic rot_result_t rotate_vector(rot_word_t w);
        rot_result_t r;
        longint vec[3], ax[3], mat[3][3];
        longint len2, len, ux, uy, uz, cx, cy, z, dx, dy, c, s, omc, one, acc;
        logic neg, hit;
        int atan_tab[30];
        atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                     131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                     127, 63, 31, 15, 8, 4, 2};
        vec = '{w.vx, w.vy, w.vz};
        ax = '{w.ax, w.ay, w.az};
        r = '{default: '0};
        len2 = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
        if (len2 == 0) begin
            r.zero_axis = 1'b1;
            return r;
        end
        len = root_nearest(len2);
        ux = unit_part(ax[0], len);
        uy = unit_part(ax[1], len);
        uz = unit_part(ax[2], len);
        // fold the angle into the CORDIC range, then rotate
        z = longint'(w.ang) * 131072;
        neg = 1'b0;
        if (z > 64'sd1686629713) begin
            z = z - 64'sd3373259426;
            neg = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z = z + 64'sd3373259426;
            neg = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < 30; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx = cx - dx; cy = cy + dy; z = z - atan_tab[i];
            end else begin
                cx = cx + dx; cy = cy - dy; z = z + atan_tab[i];
            end
        end
        c = round_shift(neg ? -cx : cx, 15);
        s = round_shift(neg ? -cy : cy, 15);
        // matrix in Q.45
        one = longint'(1) << 30;
        omc = 32768 - c;
        mat[0][0] = ux * ux * 32768 + (one - ux * ux) * c;
        mat[0][1] = ux * uy * omc - uz * s * 32768;
        mat[0][2] = ux * uz * omc + uy * s * 32768;
        mat[1][0] = ux * uy * omc + uz * s * 32768;
        mat[1][1] = uy * uy * 32768 + (one - uy * uy) * c;
        mat[1][2] = uy * uz * omc - ux * s * 32768;
        mat[2][0] = ux * uz * omc - uy * s * 32768;
        mat[2][1] = uy * uz * omc + ux * s * 32768;
        mat[2][2] = uz * uz * 32768 + (one - uz * uz) * c;
        hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc = round_shift(mat[i][0], 17) * vec[0] + round_shift(mat[i][1], 17) * vec[1]
                + round_shift(mat[i][2], 17) * vec[2];
            acc = round_shift(acc, 28);
            if (i == 0) r.ox = clamp16(acc, hit);
            else if (i == 1) r.oy = clamp16(acc, hit);
            else r.oz = clamp16(acc, hit);
        end
        r.clipped = hit;
        return r;
    endfunction

    task automatic add_row(int vx, int vy, int vz, int ax, int ay, int az, int ang,
                           bit typed = 1'b0);
        stim_row_t row;
        row.w = '{vx[15:0], vy[15:0], vz[15:0], ax[15:0], ay[15:0], az[15:0], ang[15:0]};
        row.typed = typed;
        // only zero-axis rows carry a typed answer: all zero, flag set
        row.res = '{ox: 16'sd0, oy: 16'sd0, oz: 16'sd0, zero_axis: 1'b1, clipped: 1'b0};
        stim_table = {stim_table, row};
    endtask

    function automatic rot_word_t random_word();
        rot_word_t w;
        int pick;
        w.vx = 16'($urandom); w.vy = 16'($urandom); w.vz = 16'($urandom);
        w.ax = 16'($urandom); w.ay = 16'($urandom); w.az = 16'($urandom);
        w.ang = 16'(int'($urandom_range(0, 51472)) - 25736);
        pick = int'($urandom_range(0, 19));
        // small axes stress the normalizer rounding
        if (pick < 4) begin
            w.ax = 16'(int'($urandom_range(0, 6)) - 3);
            w.ay = 16'(int'($urandom_range(0, 6)) - 3);
            w.az = 16'(int'($urandom_range(0, 6)) - 3);
        end else if (pick == 4) begin
            w.ax = '0; w.ay = '0; w.az = '0;
        end else if (pick == 5) begin
            w.ang = 16'($urandom);
        end else if (pick < 9) begin
            w.vx = 16'(int'($urandom_range(0, 8192)) - 4096);
            w.vy = 16'(int'($urandom_range(0, 8192)) - 4096);
            w.vz = 16'(int'($urandom_range(0, 8192)) - 4096);
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", words_out, what, got, want);
        mismatches++;
    endtask

    // send one word after an optional idle gap, wait for its handshake
    task automatic send_word(rot_word_t w, bit typed, rot_result_t typed_res);
        int gap;
        rot_result_t exp_res;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = int'($urandom_range(1, 3));
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {w.ang, w.az, w.ay, w.ax, w.vz, w.vy, w.vx};
        do @(posedge aclk); while (!s_tready);
        exp_res = typed ? typed_res : rotate_vector(w);
        expected_rotations = {expected_rotations, exp_res};
        words_in++;
        @(negedge aclk);
    endtask

    // check each result word against the oldest expectation
    always @(posedge aclk) begin
        rot_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rotations.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = expected_rotations.pop_front();
                if (m_tdata[15:0] !== want.ox) report_mismatch("out_x",
                    int'($signed(m_tdata[15:0])), int'(want.ox));
                if (m_tdata[31:16] !== want.oy) report_mismatch("out_y",
                    int'($signed(m_tdata[31:16])), int'(want.oy));
                if (m_tdata[47:32] !== want.oz) report_mismatch("out_z",
                    int'($signed(m_tdata[47:32])), int'(want.oz));
                if (m_tuser[0] !== want.zero_axis) report_mismatch("axis_zero",
                    int'(m_tuser[0]), int'(want.zero_axis));
                if (m_tuser[1] !== want.clipped) report_mismatch("saturated",
                    int'(m_tuser[1]), int'(want.clipped));
                if (want.clipped) clipped_seen++;
                if (want.zero_axis) zero_seen++;
            end
            words_out++;
        end
    end

    // stall the result side in random bursts, except in reset or the quiet phase
    always @(negedge aclk) begin
        if (!aresetn || quiet) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = int'($urandom_range(0, 2));
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        rot_result_t none;
        int settle;
        none = '{default: '0};
        // zero axes, extremes, both angle limits, clipping, out-of-range angles
        add_row(4096, 0, 0, 0, 0, 0, 0, 1'b1);
        add_row(32767, -32768, 32767, 0, 0, 0, 25736, 1'b1);
        add_row(-32768, -32768, -32768, 0, 0, 0, -32768, 1'b1);
        add_row(4096, 0, 0, 0, 0, 4096, 0);
        add_row(4096, 0, 0, 0, 0, 4096, 12868);
        add_row(4096, 0, 0, 0, 0, 4096, 25736);
        add_row(4096, 0, 0, 0, 0, 4096, -25736);
        add_row(4096, 4096, 4096, 1, 1, 1, 8579);
        add_row(32767, 32767, 0, 0, 0, 1, 6434);
        add_row(-32768, -32768, 0, 0, 0, 32767, 6434);
        add_row(32767, 32767, 32767, -32768, -32768, -32768, 25736);
        add_row(-32768, 32767, -32768, 32767, -32768, 32767, -25736);
        add_row(1, -1, 1, -32768, 0, 0, 32767);
        add_row(4096, -4096, 2048, 0, -32768, 0, -32768);
        add_row(12345, -54321, 7777, 1, 0, 0, 12869);
        add_row(100, 200, 300, 0, 1, 0, -12869);
        add_row(-1, 0, 32767, 3, -4, 12, 1);
        add_row(0, 0, 0, 32767, 32767, 32767, 20000);
        add_row(32767, 0, 0, 0, 32767, 0, 12868);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_table[i]) send_word(stim_table[i].w, stim_table[i].typed,
                                          stim_table[i].res);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n > RAND_ITEMS * 85 / 100) quiet = 1'b1;
            send_word(random_word(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        settle = 0;
        while (expected_rotations.size() != 0) @(posedge aclk);
        while (settle < 2 * LATENCY) begin
            @(posedge aclk);
            settle++;
        end

        $display("rotated %0d words (%0d directed), %0d clipped, %0d zero-axis",
                 words_in, stim_table.size(), clipped_seen, zero_seen);
        $display("%0d mismatches seen", mismatches);
        if (mismatches == 0 && expected_rotations.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
